### rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operand widths, word layouts, opcodes and the control/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

    // operand and internal widths
    localparam int OPERAND_WIDTH = 16;
    localparam int CMD_W         = 3;
    localparam int NUM_W         = OPERAND_WIDTH;
    localparam int DEN_W         = OPERAND_WIDTH - 1;
    localparam int MUL_W         = OPERAND_WIDTH + 1;
    localparam int WIDE_W        = 2 * OPERAND_WIDTH;
    localparam int CNT_W         = $clog2(WIDE_W);

    // result field widths
    localparam int RES_NUM_W     = 32;
    localparam int RES_DEN_W     = 31;
    localparam int CMP_W         = 2;

    // input word layout, lowest bit first
    localparam int CMD_LSB       = 0;
    localparam int A_NUM_LSB     = CMD_LSB + CMD_W;
    localparam int A_DEN_LSB     = A_NUM_LSB + NUM_W;
    localparam int B_NUM_LSB     = A_DEN_LSB + DEN_W;
    localparam int B_DEN_LSB     = B_NUM_LSB + NUM_W;
    localparam int IN_BITS       = B_DEN_LSB + DEN_W;
    localparam int S_TDATA_W     = ((IN_BITS + 7) / 8) * 8;

    // result word layout, lowest bit first
    localparam int OUT_BITS      = RES_NUM_W + RES_DEN_W + CMP_W + 1;
    localparam int M_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

    // opcodes
    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NEG = 3'd5;

    // product slot selected for the shared multiplier
    typedef enum logic [1:0] {
        MUL_P0 = 2'd0,
        MUL_P1 = 2'd1,
        MUL_P2 = 2'd2
    } mul_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     form;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     write;
    } rau_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic reduce;
        logic gcd_done;
    } rau_stat_t;

    // one restoring-division lane: partial remainder and dividend/quotient
    typedef struct packed {
        logic [WIDE_W-1:0] rem;
        logic [WIDE_W-1:0] quo;
    } div_lane_t;

endpackage

### rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing state machine of the rational arithmetic unit
// Steps one word through multiply, form, GCD and divide phases and owns
// the input ready and the output valid.
// ----------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  rau_stat_t stat,
    output rau_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_FORM  = 6'b000100,
        ST_GCD   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t            state_reg,   state_next;
    mul_sel_t          mul_sel_reg, mul_sel_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic              valid_reg,   valid_next;
    logic              out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        mul_sel_next = mul_sel_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = mul_sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load     = 1'b1;
                    mul_sel_next = MUL_P0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                unique case (mul_sel_reg)
                    MUL_P0:  mul_sel_next = MUL_P1;
                    MUL_P1:  mul_sel_next = MUL_P2;
                    default: state_next   = ST_FORM;
                endcase
            end
            ST_FORM: begin
                cmd.form   = 1'b1;
                state_next = stat.reduce ? ST_GCD : ST_WRITE;
            end
            ST_GCD: begin
                if (stat.gcd_done) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDE_W - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid: set on write, cleared when taken
    always_comb begin
        priority if (cmd.write) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mul_sel_reg <= MUL_P0;
            cnt_reg     <= '0;
            valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mul_sel_reg <= mul_sel_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
        end
    end

endmodule

### rtl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Shared multiplier, result forming and sign normalization, binary GCD
// and a two-lane restoring divider that reduces numerator and denominator.
// ----------------------------------------------------------------------------
module rau_dp
    import rau_pkg::*;
(
    input  logic                        aclk,
    input  rau_cmd_t                    cmd,
    output rau_stat_t                   stat,
    input  logic [CMD_W-1:0]            in_cmd,
    input  logic signed [NUM_W-1:0]     in_a_num,
    input  logic [DEN_W-1:0]            in_a_den,
    input  logic signed [NUM_W-1:0]     in_b_num,
    input  logic [DEN_W-1:0]            in_b_den,
    output logic signed [RES_NUM_W-1:0] res_num,
    output logic [RES_DEN_W-1:0]        res_den,
    output logic signed [CMP_W-1:0]     cmp_sign,
    output logic                        zero_den_error
);

    // one restoring-division step
    function automatic div_lane_t div_step_f(input div_lane_t lane,
                                             input logic [WIDE_W-1:0] dvsr);
        logic [WIDE_W:0] shifted;
        div_lane_t       res;
        shifted = {lane.rem, lane.quo[WIDE_W-1]};
        if (shifted >= {1'b0, dvsr}) begin
            res.rem = WIDE_W'(shifted - {1'b0, dvsr});
            res.quo = {lane.quo[WIDE_W-2:0], 1'b1};
        end else begin
            res.rem = WIDE_W'(shifted);
            res.quo = {lane.quo[WIDE_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // operand registers
    logic [CMD_W-1:0]           cmd_reg;
    logic signed [NUM_W-1:0]    an_reg, bn_reg;
    logic [DEN_W-1:0]           ad_reg, bd_reg;

    // products
    logic signed [WIDE_W-1:0]   p0_reg, p1_reg, p2_reg;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_full;
    logic signed [WIDE_W-1:0]   mul_p;

    // formed fraction
    logic signed [WIDE_W-1:0]   raw_num, raw_den, f_num, f_den;
    logic [WIDE_W-1:0]          f_mag;
    logic                       f_den_zero;
    logic signed [CMP_W-1:0]    f_cmp;

    // working registers
    logic                       sign_reg;
    logic [WIDE_W-1:0]          mag_reg, den_reg;
    logic                       err_reg;
    logic signed [CMP_W-1:0]    cmp_reg;
    logic [WIDE_W-1:0]          x_reg, y_reg, g_reg;
    logic [CNT_W-1:0]           k_reg;
    logic [WIDE_W-1:0]          rn_reg, rd_reg;
    div_lane_t                  lane_n, lane_d;
    logic signed [WIDE_W-1:0]   out_num;

    // output registers
    logic signed [RES_NUM_W-1:0] res_num_reg;
    logic [RES_DEN_W-1:0]        res_den_reg;
    logic signed [CMP_W-1:0]     cmp_out_reg;
    logic                        err_out_reg;

    // operand selection for the shared multiplier
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_P0: begin
                mul_a = MUL_W'(an_reg);
                mul_b = (cmd_reg == CMD_MUL) ? MUL_W'(bn_reg) : $signed({2'b00, bd_reg});
            end
            MUL_P1: begin
                mul_a = $signed({2'b00, ad_reg});
                mul_b = MUL_W'(bn_reg);
            end
            default: begin
                mul_a = $signed({2'b00, ad_reg});
                mul_b = $signed({2'b00, bd_reg});
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_p    = WIDE_W'(mul_full);

    // raw fraction per opcode
    always_comb begin
        unique case (cmd_reg)
            CMD_ADD: begin
                raw_num = p0_reg + p1_reg;
                raw_den = p2_reg;
            end
            CMD_SUB, CMD_CMP: begin
                raw_num = p0_reg - p1_reg;
                raw_den = p2_reg;
            end
            CMD_MUL: begin
                raw_num = p0_reg;
                raw_den = p2_reg;
            end
            CMD_DIV: begin
                raw_num = p0_reg;
                raw_den = p1_reg;
            end
            CMD_NEG: begin
                raw_num = -WIDE_W'(an_reg);
                raw_den = $signed(WIDE_W'(ad_reg));
            end
            default: begin
                raw_num = '0;
                raw_den = WIDE_W'(1);
            end
        endcase
    end

    // sign normalization and reduce decision
    always_comb begin
        f_num      = raw_den[WIDE_W-1] ? -raw_num : raw_num;
        f_den      = raw_den[WIDE_W-1] ? -raw_den : raw_den;
        f_mag      = f_num[WIDE_W-1] ? WIDE_W'(-f_num) : WIDE_W'(f_num);
        f_den_zero = (f_den == '0);
        if (cmd_reg != CMD_CMP || raw_num == '0) begin
            f_cmp = '0;
        end else if (raw_num[WIDE_W-1]) begin
            f_cmp = -CMP_W'(1);
        end else begin
            f_cmp = CMP_W'(1);
        end
    end

    assign stat.reduce   = !f_den_zero && (f_mag >= WIDE_W'(2));
    assign stat.gcd_done = (x_reg == y_reg);

    assign lane_n  = div_step_f({rn_reg, mag_reg}, g_reg);
    assign lane_d  = div_step_f({rd_reg, den_reg}, g_reg);
    assign out_num = sign_reg ? -$signed(mag_reg) : $signed(mag_reg);

    // operands and products
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_cmd;
            an_reg  <= in_a_num;
            ad_reg  <= in_a_den;
            bn_reg  <= in_b_num;
            bd_reg  <= in_b_den;
        end
        if (cmd.mul_en) begin
            unique case (cmd.mul_sel)
                MUL_P0:  p0_reg <= mul_p;
                MUL_P1:  p1_reg <= mul_p;
                default: p2_reg <= mul_p;
            endcase
        end
    end

    // form, binary GCD and division
    always_ff @(posedge aclk) begin
        if (cmd.form) begin
            sign_reg <= f_num[WIDE_W-1] && !f_den_zero;
            mag_reg  <= f_den_zero ? '0 : f_mag;
            den_reg  <= WIDE_W'(f_den);
            err_reg  <= f_den_zero;
            cmp_reg  <= f_cmp;
            x_reg    <= f_mag;
            y_reg    <= WIDE_W'(f_den);
            k_reg    <= '0;
        end else if (cmd.gcd_step) begin
            priority if (!x_reg[0] && !y_reg[0]) begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!x_reg[0]) begin
                x_reg <= x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_reg <= y_reg >> 1;
            end else if (x_reg > y_reg) begin
                x_reg <= (x_reg - y_reg) >> 1;
            end else begin
                y_reg <= (y_reg - x_reg) >> 1;
            end
        end else if (cmd.div_init) begin
            g_reg  <= x_reg << k_reg;
            rn_reg <= '0;
            rd_reg <= '0;
        end else if (cmd.div_step) begin
            rn_reg  <= lane_n.rem;
            mag_reg <= lane_n.quo;
            rd_reg  <= lane_d.rem;
            den_reg <= lane_d.quo;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            res_num_reg <= RES_NUM_W'(out_num);
            res_den_reg <= RES_DEN_W'(den_reg);
            cmp_out_reg <= cmp_reg;
            err_out_reg <= err_reg;
        end
    end

    assign res_num        = res_num_reg;
    assign res_den        = res_den_reg;
    assign cmp_sign       = cmp_out_reg;
    assign zero_den_error = err_out_reg;

endmodule

### rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/sub/mul/div/compare/negate
// Top level: stream ports, word packing, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   One input word carries an opcode and two fractions a and b. Each word
//   gives exactly one result word: the normalized fraction (denominator
//   made positive, reduced by the GCD when the numerator magnitude is 2 or
//   more), the compare sign, and an error flag for a zero denominator.
//   Steps: three products through one shared multiplier, a forming step,
//   then when reducing a binary GCD of one step per cycle and a radix-2
//   restoring divider over the 32-bit lanes. The GCD loop and the divider
//   set the time from accept to m_tvalid. One word is in flight at a time;
//   the next word can be taken in the cycle after its result is written.
//   s_tready is high only while the unit is idle; the next word may be
//   taken while a finished result still waits in the output register.
//   If the receiver stalls, the unit holds its next result until the
//   output register frees. Reset clears control state only.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // tdata: cmd[3], a_num[16], a_den[15], b_num[16], b_den[15], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: res_num[32], res_den[31], cmp_sign[2], zero_den_error[1], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    rau_cmd_t                    cmd;
    rau_stat_t                   stat;
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic signed [CMP_W-1:0]     cmp_sign;
    logic                        zero_den_error;

    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rau_dp u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .stat           (stat),
        .in_cmd         (s_tdata[CMD_LSB +: CMD_W]),
        .in_a_num       ($signed(s_tdata[A_NUM_LSB +: NUM_W])),
        .in_a_den       (s_tdata[A_DEN_LSB +: DEN_W]),
        .in_b_num       ($signed(s_tdata[B_NUM_LSB +: NUM_W])),
        .in_b_den       (s_tdata[B_DEN_LSB +: DEN_W]),
        .res_num        (res_num),
        .res_den        (res_den),
        .cmp_sign       (cmp_sign),
        .zero_den_error (zero_den_error)
    );

    // result word packing
    assign m_tdata = M_TDATA_W'({zero_den_error, cmp_sign, res_den, res_num});

    // an error result is exactly 0/0
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && zero_den_error |-> (res_num == '0) && (res_den == '0))
        else $error("error result not 0/0");

    // a good result never has a zero denominator
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !zero_den_error |-> res_den != '0)
        else $error("zero denominator without error flag");

    // compare sign is -1, 0 or +1
    a_cmp_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> cmp_sign != 2'b10)
        else $error("bad compare sign");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

endmodule
